// ===== sv/ldpcms_pkg.sv =====
package ldpcms_pkg;

  localparam int MSG_BITS_DEF  = 8;
  localparam int SCALE_BITS    = 9;
  localparam int OFFSET_BITS   = 7;
  localparam int SCALE_SHIFT   = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [SCALE_BITS-1:0]  NORM_SCALE_RST    = 9'd211;
  localparam logic [OFFSET_BITS-1:0] OFFSET_AMOUNT_RST = 7'd0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORM_SCALE    = 2'd0,
    REG_OFFSET_AMOUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    MODE_ACCUMULATE = 1'b0,
    MODE_REGENERATE = 1'b1
  } mode_t;

  typedef struct packed {
    logic sign_parity;
    logic frame_syndrome;
  } chk_status_t;

endpackage

// ===== sv/ldpcms_if.sv =====
interface ldpcms_v2c_if #(parameter int MSG_BITS = ldpcms_pkg::MSG_BITS_DEF) ();
  logic                       valid;
  logic                       ready;
  ldpcms_pkg::mode_t          mode;
  logic signed [MSG_BITS-1:0] v2c_msg;
  logic                       last_of_check;
  logic                       start_of_frame;

  modport source(output valid, mode, v2c_msg, last_of_check, start_of_frame, input ready);
  modport sink(input valid, mode, v2c_msg, last_of_check, start_of_frame, output ready);
endinterface

interface ldpcms_c2v_if #(parameter int MSG_BITS = ldpcms_pkg::MSG_BITS_DEF) ();
  logic                       valid;
  logic                       ready;
  logic signed [MSG_BITS-1:0] c2v_msg;
  logic                       last_out;
  logic                       check_failed;
  logic                       frame_ok;

  modport source(output valid, c2v_msg, last_out, check_failed, frame_ok, input ready);
  modport sink(input valid, c2v_msg, last_out, check_failed, frame_ok, output ready);
endinterface

interface ldpcms_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [ldpcms_pkg::CFG_IDX_BITS-1:0]  index;
  logic [ldpcms_pkg::CFG_DATA_BITS-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ldpcms_acc.sv =====
module ldpcms_acc #(
  parameter int MSG_BITS = ldpcms_pkg::MSG_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  ldpcms_pkg::mode_t       mode,
  input  logic [MSG_BITS-2:0]     mag,
  input  logic                    neg,
  input  logic                    last,
  input  logic                    sof,
  output logic [MSG_BITS-2:0]     min_first,
  output logic [MSG_BITS-2:0]     min_second,
  output ldpcms_pkg::chk_status_t status
);
  import ldpcms_pkg::*;

  localparam int MAG_BITS = MSG_BITS - 1;
  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

  logic                check_fresh;
  logic [MAG_BITS-1:0] base_first;
  logic [MAG_BITS-1:0] base_second;
  logic                base_parity;
  logic [MAG_BITS-1:0] hi;
  logic [MAG_BITS-1:0] min_first_next;
  logic [MAG_BITS-1:0] min_second_next;
  logic                parity_next;
  logic                syndrome_next;

  always_comb begin
    base_first      = check_fresh ? MAG_MAX : min_first;
    base_second     = check_fresh ? MAG_MAX : min_second;
    base_parity     = check_fresh ? 1'b0 : status.sign_parity;
    hi              = (mag > base_first) ? mag : base_first;
    min_second_next = (hi < base_second) ? hi : base_second;
    min_first_next  = (mag < base_first) ? mag : base_first;
    parity_next     = base_parity ^ neg;
    syndrome_next   = (sof ? 1'b0 : status.frame_syndrome) | (last & parity_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_first             <= MAG_MAX;
      min_second            <= MAG_MAX;
      status.sign_parity    <= 1'b0;
      status.frame_syndrome <= 1'b0;
      check_fresh           <= 1'b1;
    end else if (en && mode == MODE_ACCUMULATE) begin
      min_first             <= min_first_next;
      min_second            <= min_second_next;
      status.sign_parity    <= parity_next;
      status.frame_syndrome <= syndrome_next;
      check_fresh           <= last;
    end
  end

`ifndef ASSERT_OFF
  a_min_order: assert property (@(posedge clk) disable iff (rst)
    min_first <= min_second)
    else $error("first minimum above second minimum");

  a_fresh_after_last: assert property (@(posedge clk) disable iff (rst)
    (en && mode == MODE_ACCUMULATE && last) |=> check_fresh)
    else $error("check not restarted after its last accumulate beat");

  a_regen_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (en && mode == MODE_REGENERATE) |=> $stable(min_first) && $stable(min_second)
      && $stable(status))
    else $error("regenerate beat changed check state");
`endif

endmodule

// ===== sv/ldpcms_regen.sv =====
module ldpcms_regen #(
  parameter int MSG_BITS = ldpcms_pkg::MSG_BITS_DEF
) (
  input  logic [MSG_BITS-2:0]                mag,
  input  logic                               neg,
  input  logic [MSG_BITS-2:0]                min_first,
  input  logic [MSG_BITS-2:0]                min_second,
  input  ldpcms_pkg::chk_status_t            status,
  input  logic [ldpcms_pkg::SCALE_BITS-1:0]  norm_scale,
  input  logic [ldpcms_pkg::OFFSET_BITS-1:0] offset_amount,
  output logic [MSG_BITS-1:0]                c2v_msg
);
  import ldpcms_pkg::*;

  localparam int MAG_BITS  = MSG_BITS - 1;
  localparam int W         = (MAG_BITS > OFFSET_BITS) ? MAG_BITS : OFFSET_BITS;
  localparam int PROD_BITS = W + SCALE_BITS;
  localparam int SC_BITS   = PROD_BITS - SCALE_SHIFT;
  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

  logic [MAG_BITS-1:0]  sel;
  logic [W-1:0]         sel_w;
  logic [W-1:0]         off_w;
  logic [W-1:0]         diff;
  logic [PROD_BITS-1:0] prod;
  logic [SC_BITS-1:0]   scaled;
  logic [MAG_BITS-1:0]  res;
  logic [MSG_BITS-1:0]  res_ext;

  always_comb begin
    sel     = (mag == min_first) ? min_second : min_first;
    sel_w   = W'(sel);
    off_w   = W'(offset_amount);
    diff    = (sel_w > off_w) ? sel_w - off_w : '0;
    prod    = PROD_BITS'(diff) * PROD_BITS'(norm_scale);
    scaled  = prod[PROD_BITS-1:SCALE_SHIFT];
    res     = (scaled > SC_BITS'(MAG_MAX)) ? MAG_MAX : scaled[MAG_BITS-1:0];
    res_ext = {1'b0, res};
    c2v_msg = ((status.sign_parity ^ neg) && res != '0) ? -res_ext : res_ext;
  end

endmodule

// ===== sv/ldpc_min_sum_check_node.sv =====
// Check node unit for offset/normalized min-sum LDPC decoding. Each check is
// fed twice: an accumulate pass (mode 0) that folds the v2c messages into two
// minima and a sign parity and gives no result, then a regenerate pass
// (mode 1) with the same messages, one c2v beat per message. One message is
// taken every clock cycle in either pass; a result is offered on c2v from the
// result register after its message passes the input register, and the only
// stall comes from c2v holding ready low. The user must write norm_scale and
// offset_amount through cfg while no message is in flight; this is not enforced.
module ldpc_min_sum_check_node #(
  parameter int MSG_BITS = ldpcms_pkg::MSG_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  ldpcms_cfg_if.sink             cfg,
  ldpcms_v2c_if.sink             v2c,
  ldpcms_c2v_if.source           c2v
);
  import ldpcms_pkg::*;

  localparam int MAG_BITS = MSG_BITS - 1;
  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
  localparam logic [MSG_BITS-1:0] MSG_MIN = {1'b1, {MAG_BITS{1'b0}}};

  logic [SCALE_BITS-1:0]  norm_scale;
  logic [OFFSET_BITS-1:0] offset_amount;

  logic                s1_valid;
  mode_t               s1_mode;
  logic [MSG_BITS-1:0] s1_msg;
  logic                s1_last;
  logic                s1_sof;
  logic                s1_go;

  logic                neg;
  logic [MSG_BITS-1:0] neg_v;
  logic [MAG_BITS-1:0] mag;

  logic [MAG_BITS-1:0] min_first;
  logic [MAG_BITS-1:0] min_second;
  chk_status_t         status;
  logic [MSG_BITS-1:0] c2v_next;

  logic                res_valid;
  logic [MSG_BITS-1:0] res_msg;
  logic                res_last;
  logic                res_failed;
  logic                res_ok;

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_scale    <= NORM_SCALE_RST;
      offset_amount <= OFFSET_AMOUNT_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_NORM_SCALE:    norm_scale    <= cfg.data[SCALE_BITS-1:0];
        REG_OFFSET_AMOUNT: offset_amount <= cfg.data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  assign s1_go     = s1_valid && (s1_mode == MODE_ACCUMULATE || !res_valid || c2v.ready);
  assign v2c.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (v2c.ready) begin
      s1_valid <= v2c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (v2c.valid && v2c.ready) begin
      s1_mode <= v2c.mode;
      s1_msg  <= v2c.v2c_msg;
      s1_last <= v2c.last_of_check;
      s1_sof  <= v2c.start_of_frame;
    end
  end

  // magnitude, most negative saturates
  always_comb begin
    neg   = s1_msg[MSG_BITS-1];
    neg_v = -s1_msg;
    if (!neg) begin
      mag = s1_msg[MAG_BITS-1:0];
    end else if (neg_v[MSG_BITS-1]) begin
      mag = MAG_MAX;
    end else begin
      mag = neg_v[MAG_BITS-1:0];
    end
  end

  ldpcms_acc #(.MSG_BITS(MSG_BITS)) u_acc (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_go),
    .mode       (s1_mode),
    .mag        (mag),
    .neg        (neg),
    .last       (s1_last),
    .sof        (s1_sof),
    .min_first  (min_first),
    .min_second (min_second),
    .status     (status)
  );

  ldpcms_regen #(.MSG_BITS(MSG_BITS)) u_regen (
    .mag           (mag),
    .neg           (neg),
    .min_first     (min_first),
    .min_second    (min_second),
    .status        (status),
    .norm_scale    (norm_scale),
    .offset_amount (offset_amount),
    .c2v_msg       (c2v_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_mode == MODE_REGENERATE) begin
      res_valid <= 1'b1;
    end else if (c2v.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_mode == MODE_REGENERATE) begin
      res_msg    <= c2v_next;
      res_last   <= s1_last;
      res_failed <= status.sign_parity;
      res_ok     <= !status.frame_syndrome;
    end
  end

  assign c2v.valid        = res_valid;
  assign c2v.c2v_msg      = res_msg;
  assign c2v.last_out     = res_last;
  assign c2v.check_failed = res_failed;
  assign c2v.frame_ok     = res_ok;

`ifndef ASSERT_OFF
  a_result_from_regen: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_go && s1_mode == MODE_REGENERATE))
    else $error("result beat without a regenerate beat");

  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_msg != MSG_MIN)
    else $error("c2v message not saturated");

  a_parity_carried: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_mode == MODE_REGENERATE) |=>
      res_valid && res_failed == $past(status.sign_parity))
    else $error("check_failed does not follow sign parity");
`endif

endmodule
